### hw/rtl/tmrs_pkg.sv
// Shared constants and types for the octal MSD radix sorter.
// No dependencies; the sorter top level, the bucket counter and the checker import this package.
package tmrs_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int KEY_BITS   = 63;
    localparam int IDX_W      = 6;
    localparam int RADIX_BINS = 8;
    localparam int DIG_W      = 3;
    localparam int LVL_W      = 6;
    localparam int SHIFT_W    = 7;
    localparam int STACK_DEPTH = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int ENTRY_W    = KEY_BITS + IDX_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEAF_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SHIFT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LEVEL     = 2'd2;

    // One node of the sort tree: a range of the store plus its digit position.
    typedef struct packed {
        logic [ADDR_W-1:0]         lo;
        logic [CNT_W-1:0]          n;
        logic signed [SHIFT_W-1:0] shift;
        logic [LVL_W-1:0]          level;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Controls from the sequencer to the bucket counter.
    typedef struct packed {
        logic             clr;
        logic             count_en;
        logic             prefix_en;
        logic             scatter_en;
        logic [DIG_W-1:0] digit;
        logic [DIG_W-1:0] sel;
    } bkt_ctrl_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_COPY,
        ST_PUSH,
        ST_POP,
        ST_POP_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT
    } state_t;

endpackage

### hw/rtl/truncated_msd_radix_sort_octal.sv
// Octal MSD radix sorter: loads one request per cycle, then sorts and emits.
// Each split runs count, scatter and copy passes over the node's n entries
// through the store RAMs, whose read data is registered, then one push step per bucket.
// Each pop reads the stack top; each result is emitted by a read, a wait and an output step.
// Reset clears the control state, the load count and the digit counts; the
// stores are not cleared and only entries of the current set are ever read.
module truncated_msd_radix_sort_octal
    import tmrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KEY_BITS-1:0]   code,
    input  logic [IDX_W-1:0]      item_index,
    input  logic                  last_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KEY_BITS-1:0]   sorted_code,
    output logic [IDX_W-1:0]      sorted_index,
    output logic [LVL_W-1:0]      leaf_level,
    output logic                  leaf_start,
    output logic                  last_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    node_t             node_reg, node_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              pipe_v_reg, pipe_v_next;
    logic [ADDR_W-1:0] addr_d_reg, addr_d_next;
    logic [DIG_W-1:0]  b_reg, b_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic [CNT_W-1:0]  thr_reg;
    logic [5:0]        start_shift_reg;
    logic [3:0]        root_level_reg;

    logic [KEY_BITS-1:0] out_code_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic [LVL_W-1:0]    out_level_reg;
    logic                out_start_reg;
    logic                out_last_reg;

    logic                a_we, b_we, s_we;
    logic [ADDR_W-1:0]   a_waddr, a_raddr, b_waddr, b_raddr, s_waddr, s_raddr;
    logic [ENTRY_W-1:0]  a_wdata, a_rdata, b_wdata, b_rdata;
    node_t               s_wdata, s_rdata;
    logic [NODE_W-1:0]   s_rdata_raw;

    bkt_ctrl_t           bk;
    logic [CNT_W-1:0]    bk_dst, bk_count, bk_start;

    logic [KEY_BITS-1:0] rd_key, sh_key;
    logic [DIG_W-1:0]    cur_digit;
    logic                issue;

    // Working store, scatter buffer and node stack.
    tmrs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ITEMS)) u_store_a (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    tmrs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ITEMS)) u_store_b (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    tmrs_ram #(.WIDTH(NODE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata_raw)
    );

    assign s_rdata = node_t'(s_rdata_raw);

    tmrs_bucket u_bucket (
        .clk(clk), .rst_n(rst_n), .ctrl(bk),
        .dst_off(bk_dst), .sel_count(bk_count), .sel_start(bk_start)
    );

    // Digit of the entry just read from the working store.
    assign rd_key    = a_rdata[ENTRY_W-1:IDX_W];
    assign sh_key    = rd_key >> node_reg.shift[5:0];
    assign cur_digit = sh_key[DIG_W-1:0];
    assign issue     = (i_reg < node_reg.n);

    // Sequencer: next state and memory controls.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        node_next       = node_reg;
        top_next        = top_reg;
        i_next          = i_reg;
        pipe_v_next     = 1'b0;
        b_next          = b_reg;
        out_valid_next  = out_valid_reg;
        out_load        = 1'b0;
        in_ready        = 1'b0;

        a_raddr     = node_reg.lo + i_reg[ADDR_W-1:0];
        b_raddr     = node_reg.lo + i_reg[ADDR_W-1:0];
        addr_d_next = node_reg.lo + i_reg[ADDR_W-1:0];
        a_we        = 1'b0;
        a_waddr     = addr_d_reg;
        a_wdata     = b_rdata;
        b_we        = 1'b0;
        b_waddr     = node_reg.lo + bk_dst[ADDR_W-1:0];
        b_wdata     = a_rdata;
        s_we        = 1'b0;
        s_waddr     = top_reg[ADDR_W-1:0];
        s_raddr     = top_reg[ADDR_W-1:0] - 1'b1;

        s_wdata.lo    = node_reg.lo + bk_start[ADDR_W-1:0];
        s_wdata.n     = bk_count;
        s_wdata.shift = node_reg.shift - 7'sd3;
        s_wdata.level = node_reg.level + 1'b1;

        bk.clr        = 1'b0;
        bk.count_en   = 1'b0;
        bk.prefix_en  = 1'b0;
        bk.scatter_en = 1'b0;
        bk.digit      = cur_digit;
        bk.sel        = b_reg;

        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    a_we            = 1'b1;
                    a_waddr         = load_count_reg[ADDR_W-1:0];
                    a_wdata         = {code, item_index};
                    load_count_next = load_count_reg + 1'b1;
                    if (last_in || load_count_reg == CNT_W'(MAX_ITEMS - 1))
                    begin
                        node_next.lo    = '0;
                        node_next.n     = load_count_reg + 1'b1;
                        node_next.shift = SHIFT_W'({1'b0, start_shift_reg});
                        node_next.level = LVL_W'(root_level_reg);
                        state_next      = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                i_next = '0;
                if (node_reg.n <= thr_reg || node_reg.shift < 0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    bk.clr     = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (issue)
                begin
                    i_next      = i_reg + 1'b1;
                    pipe_v_next = 1'b1;
                end
                if (pipe_v_reg)
                begin
                    bk.count_en = 1'b1;
                end
                if (!issue && !pipe_v_reg)
                begin
                    i_next     = '0;
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                bk.prefix_en = 1'b1;
                state_next   = ST_SCATTER;
            end
            ST_SCATTER:
            begin
                if (issue)
                begin
                    i_next      = i_reg + 1'b1;
                    pipe_v_next = 1'b1;
                end
                if (pipe_v_reg)
                begin
                    b_we          = 1'b1;
                    bk.scatter_en = 1'b1;
                end
                if (!issue && !pipe_v_reg)
                begin
                    i_next     = '0;
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (issue)
                begin
                    i_next      = i_reg + 1'b1;
                    pipe_v_next = 1'b1;
                end
                if (pipe_v_reg)
                begin
                    a_we = 1'b1;
                end
                if (!issue && !pipe_v_reg)
                begin
                    i_next     = '0;
                    b_next     = 3'd7;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // Highest bucket first, so bucket zero pops next.
                if (bk_count != '0)
                begin
                    s_we     = 1'b1;
                    top_next = top_reg + 1'b1;
                end
                if (b_reg == '0)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    b_next = b_reg - 1'b1;
                end
            end
            ST_POP:
            begin
                if (top_reg == '0)
                begin
                    load_count_next = '0;
                    state_next      = ST_LOAD;
                end
                else
                begin
                    top_next   = top_reg - 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                node_next  = s_rdata;
                state_next = ST_DECIDE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (i_reg + 1'b1 == node_reg.n)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            top_reg        <= '0;
            i_reg          <= '0;
            pipe_v_reg     <= 1'b0;
            b_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            top_reg        <= top_next;
            i_reg          <= i_next;
            pipe_v_reg     <= pipe_v_next;
            b_reg          <= b_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Node and address registers carry payload only.
    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        addr_d_reg <= addr_d_next;
    end

    // Output register, loaded from the store read of the current leaf entry.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg  <= rd_key;
            out_index_reg <= a_rdata[IDX_W-1:0];
            out_level_reg <= node_reg.level;
            out_start_reg <= (i_reg == '0);
            out_last_reg  <= ({1'b0, node_reg.lo} + i_reg + 1'b1 == load_count_reg);
        end
    end

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= 7'd1;
            start_shift_reg <= 6'd60;
            root_level_reg  <= 4'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEAF_THRESHOLD: thr_reg         <= cfg_data;
                CFG_START_SHIFT:    start_shift_reg <= cfg_data[5:0];
                CFG_ROOT_LEVEL:     root_level_reg  <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign sorted_code  = out_code_reg;
    assign sorted_index = out_index_reg;
    assign leaf_level   = out_level_reg;
    assign leaf_start   = out_start_reg;
    assign last_out     = out_last_reg;

endmodule

### hw/rtl/tmrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/tmrs_bucket.sv
// Digit histogram and running bucket offsets for one split.
// Depends on tmrs_pkg.
module tmrs_bucket
    import tmrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bkt_ctrl_t        ctrl,
    output logic [CNT_W-1:0] dst_off,
    output logic [CNT_W-1:0] sel_count,
    output logic [CNT_W-1:0] sel_start
);

    logic [CNT_W-1:0] counts_reg [RADIX_BINS];
    logic [CNT_W-1:0] offs_reg [RADIX_BINS];
    logic [CNT_W-1:0] prefix [RADIX_BINS];

    // Exclusive prefix sum of the counts gives each bucket's first slot.
    always_comb
    begin
        logic [CNT_W-1:0] run;
        run = '0;
        for (int b = 0; b < RADIX_BINS; b++)
        begin
            prefix[b] = run;
            run = run + counts_reg[b];
        end
    end

    assign dst_off   = offs_reg[ctrl.digit];
    assign sel_count = counts_reg[ctrl.sel];
    // After the scatter, the offset sits at the end of its bucket.
    assign sel_start = offs_reg[ctrl.sel] - counts_reg[ctrl.sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < RADIX_BINS; b++)
            begin
                counts_reg[b] <= '0;
                offs_reg[b]   <= '0;
            end
        end
        else if (ctrl.clr)
        begin
            for (int b = 0; b < RADIX_BINS; b++)
            begin
                counts_reg[b] <= '0;
                offs_reg[b]   <= '0;
            end
        end
        else if (ctrl.count_en)
        begin
            counts_reg[ctrl.digit] <= counts_reg[ctrl.digit] + 1'b1;
        end
        else if (ctrl.prefix_en)
        begin
            for (int b = 0; b < RADIX_BINS; b++)
            begin
                offs_reg[b] <= prefix[b];
            end
        end
        else if (ctrl.scatter_en)
        begin
            offs_reg[ctrl.digit] <= offs_reg[ctrl.digit] + 1'b1;
        end
    end

endmodule

### hw/rtl/tmrs_checker.sv
// Port-level checks for the octal radix sorter, bound to the top level.
// Depends on tmrs_pkg and truncated_msd_radix_sort_octal.
module tmrs_checker
    import tmrs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                last_in,
    input logic                out_valid,
    input logic                out_ready,
    input logic [KEY_BITS-1:0] sorted_code,
    input logic                last_out
);

    // Loading and emission never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result is pending");

    // A stalled result keeps its key.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_code))
        else $error("stalled result changed");

    // The final result of a set leaves no result behind it.
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_out |=> !out_valid)
        else $error("result after the final one");

    // A final request stops loading until the set is sorted.
    a_last_in_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_in |=> !in_ready)
        else $error("request taken right after the final one");

endmodule

bind truncated_msd_radix_sort_octal tmrs_checker u_tmrs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .last_in(last_in), .out_valid(out_valid), .out_ready(out_ready),
    .sorted_code(sorted_code), .last_out(last_out)
);
